/* rtl/core/tce_pkg.sv */
// Shared types and constants for the text console engine.
`timescale 1ns / 1ps
package tce_pkg;
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_SETC  = 2'd3;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_SP  = 8'd32;

  // classified command passed from front to back
  typedef enum logic [2:0] {
    K_WRITE = 3'd0, K_NL = 3'd1, K_CR = 3'd2, K_TAB = 3'd3,
    K_BS = 3'd4, K_READ = 3'd5, K_CLEAR = 3'd6, K_SETC = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] code;
    logic [7:0] attribute;
    logic [7:0] col;   // saturated
    logic [7:0] row;   // saturated
  } cmd_t;
endpackage

/* rtl/core/tce_front.sv */
// Front end: accepts items, decodes the operation, saturates coordinates.
`timescale 1ns / 1ps
module tce_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          ready,
  input  logic [1:0]    op,
  input  logic [7:0]    code,
  input  logic [7:0]    attribute,
  input  logic [6:0]    column,
  input  logic [4:0]    row,
  output logic          q_valid,
  input  logic          q_ready,
  output tce_pkg::cmd_t q_cmd
);
  import tce_pkg::*;
  localparam int DEPTH = 2;
  cmd_t q_mem [DEPTH];
  logic wp, rp;
  logic [1:0] cnt;
  cmd_t c;

  always_comb begin
    c.code = code;
    c.attribute = attribute;
    c.col = ({1'b0, column} >= 8'(COLUMNS)) ? 8'(COLUMNS - 1) : {1'b0, column};
    c.row = ({3'b0, row} >= 8'(ROWS)) ? 8'(ROWS - 1) : {3'b0, row};
    case (op)
      OP_PUT: begin
        case (code)
          CH_NL:   c.kind = K_NL;
          CH_CR:   c.kind = K_CR;
          CH_TAB:  c.kind = K_TAB;
          CH_BS:   c.kind = K_BS;
          default: c.kind = K_WRITE;
        endcase
      end
      OP_READ:  c.kind = K_READ;
      OP_CLEAR: c.kind = K_CLEAR;
      default:  c.kind = K_SETC;
    endcase
  end

  assign ready   = (cnt != 2'(DEPTH));
  assign q_valid = (cnt != 2'd0);
  assign q_cmd   = q_mem[rp];

  always_ff @(posedge clk) begin
    if (valid && ready) q_mem[wp] <= c;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (valid && ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'(valid && ready) - 2'(q_valid && q_ready);
    end
  end
endmodule

/* rtl/core/tce_back.sv */
// Back end: cell store, cursor, scroll and clear sweeps, output register.
`timescale 1ns / 1ps
module tce_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  tce_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [10:0]   cursor,
  output logic [7:0]    cell_char,
  output logic [7:0]    cell_attr,
  output logic          scrolled
);
  import tce_pkg::*;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW = $clog2(CELLS + 1);
  localparam int CW = $clog2(COLUMNS + 1);

  typedef enum logic [7:0] {
    S_INIT = 8'b00000001, S_IDLE = 8'b00000010, S_RD = 8'b00000100,
    S_EXEC = 8'b00001000, S_SCR = 8'b00010000, S_SCRW = 8'b00100000,
    S_CLR = 8'b01000000, S_OUT = 8'b10000000
  } st_t;
  st_t st;

  logic [15:0] mem [CELLS];
  logic [15:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic [15:0] wdata;
  logic we;

  cmd_t cmd;
  logic [AW-1:0] cur;      // cursor index
  logic [CW-1:0] ccol;     // cursor column, kept alongside the index
  logic [AW-1:0] pos;      // sweep pointer
  logic [15:0] fill;
  logic [AW-1:0] rowbase;  // row*COLUMNS for read, clear and set
  logic scr;
  logic [AW:0] tab_pos;    // next tab stop index
  logic [CW:0] tab_sum, tab_col;

  always_comb begin
    tab_pos = {1'b0, cur} + (AW+1)'(4'd8 - {1'b0, cur[2:0]});
    tab_sum = {1'b0, ccol} + (CW+1)'(4'd8 - {1'b0, cur[2:0]});
    tab_col = (tab_sum >= (CW+1)'(COLUMNS)) ? tab_sum - (CW+1)'(COLUMNS) : tab_sum;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign q_ready = (st == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      st <= S_INIT; pos <= '0; cur <= '0; ccol <= '0;
      out_valid <= 1'b0; fill <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st)
        S_INIT, S_CLR: begin
          we <= 1'b1; waddr <= pos; wdata <= fill;
          if (pos == AW'(CELLS - 1)) begin
            pos <= '0;
            st <= (st == S_INIT) ? S_IDLE : S_OUT;
          end else pos <= pos + 1'b1;
        end
        S_IDLE: if (q_valid && q_ready) begin
          cmd <= q_cmd; scr <= 1'b0;
          rowbase <= AW'(q_cmd.row * COLUMNS);
          cell_char <= '0; cell_attr <= '0;
          raddr <= (cur == '0) ? '0 : cur - 1'b1;
          st <= S_RD;
        end
        S_RD: begin
          if (cmd.kind == K_READ) raddr <= rowbase + AW'(cmd.col);
          st <= S_EXEC;
        end
        S_EXEC: begin
          st <= S_OUT;
          // scroll sweep start; clear overrides pos below
          pos <= AW'(COLUMNS);
          raddr <= AW'(2 * COLUMNS);
          case (cmd.kind)
            K_WRITE: begin
              we <= 1'b1; waddr <= cur; wdata <= {cmd.attribute, cmd.code};
              if (cur == AW'(CELLS - 1)) begin
                cur <= AW'(CELLS - COLUMNS); ccol <= '0; st <= S_SCR;
              end else begin
                cur <= cur + 1'b1;
                ccol <= (ccol == CW'(COLUMNS - 1)) ? '0 : ccol + 1'b1;
              end
            end
            K_NL: begin
              if (cur >= AW'(CELLS - COLUMNS)) st <= S_SCR;
              else cur <= cur + AW'(COLUMNS);
            end
            K_CR: begin cur <= cur - AW'(ccol); ccol <= '0; end
            K_TAB: begin
              ccol <= CW'(tab_col);
              if (tab_pos >= (AW+1)'(CELLS)) begin
                cur <= AW'(tab_pos - (AW+1)'(COLUMNS)); st <= S_SCR;
              end else cur <= AW'(tab_pos);
            end
            K_BS: if (cur != '0) begin
              we <= 1'b1; waddr <= cur - 1'b1; wdata <= {rdata[15:8], CH_SP};
              cur <= cur - 1'b1;
              ccol <= (ccol == '0) ? CW'(COLUMNS - 1) : ccol - 1'b1;
            end
            K_READ: st <= S_SCRW; // reuse wait: data arrives next cycle
            K_CLEAR: begin
              cur <= rowbase + AW'(cmd.col); ccol <= CW'(cmd.col);
              fill <= {cmd.attribute, 8'h00}; pos <= '0; st <= S_CLR;
            end
            default: begin cur <= rowbase + AW'(cmd.col); ccol <= CW'(cmd.col); end
          endcase
        end
        S_SCR: begin
          // moves cell pos+COLUMNS down to pos; last row gets spaces
          scr <= 1'b1;
          st <= S_SCRW;
        end
        S_SCRW: begin
          if (cmd.kind == K_READ) begin
            cell_char <= rdata[7:0]; cell_attr <= rdata[15:8]; st <= S_OUT;
          end else begin
            we <= 1'b1; waddr <= pos;
            wdata <= (pos >= AW'(CELLS - COLUMNS)) ? {rdata[15:8], CH_SP} : rdata;
            if (pos == AW'(CELLS - 1)) st <= S_OUT;
            else begin
              pos <= pos + 1'b1;
              raddr <= (pos + 1'b1 >= AW'(CELLS - COLUMNS)) ? pos + 1'b1
                                                              : pos + AW'(COLUMNS) + 1'b1;
              st <= S_SCR;
            end
          end
        end
        S_OUT: begin
          cursor <= 11'(cur); scrolled <= scr;
          out_valid <= 1'b1; st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/text_console_engine_core.sv */
// Top level of the text console engine.
// Each item passes the front queue, then the back end's read, execute and output
// states; a read also waits for cell data, and a scroll or clear adds a sweep.
// Throughput: one item at a time in the back end, which holds each one through
// its cell store sweeps; the next starts the cycle after the result beat is taken.
// Reset: a clearing pass zeroes every cell of the store; no item leaves the queue
// until it ends.
`timescale 1ns / 1ps
module text_console_engine_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  code,
  input  logic [7:0]  attribute,
  input  logic [6:0]  column,
  input  logic [4:0]  row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] cursor,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr,
  output logic        scrolled
);
  import tce_pkg::*;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  tce_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk, .rst, .valid(in_valid), .ready(in_ready), .op, .code, .attribute,
    .column, .row, .q_valid, .q_ready, .q_cmd
  );
  tce_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .out_valid, .out_ready,
    .cursor, .cell_char, .cell_attr, .scrolled
  );
endmodule

/* rtl/core/tce_checker.sv */
// Port-level checks for the text console engine.
`timescale 1ns / 1ps
module tce_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] cursor,
  input logic [7:0]  cell_char,
  input logic        scrolled
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor))
    else $error("result beat dropped");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor < 11'd2000)
    else $error("cursor out of range");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> cell_char == 8'd0)
    else $error("scroll with read data");
endmodule

bind text_console_engine_core tce_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .cursor, .cell_char, .scrolled
);

/* sim/text_console_engine_core_tb.sv */
// Self-checking testbench for the text console engine: random and directed beats against a model.
`timescale 1ns / 1ps
module text_console_engine_core_tb;
  import tce_pkg::*;

  localparam int COLS  = 80;
  localparam int ROWSN = 25;
  localparam int CELLS = COLS * ROWSN;
  localparam int CYCLE_LIMIT = 40000000;

  typedef struct packed {
    logic [10:0] cursor;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;
  } console_out_t;

  class console_scoreboard;
    logic [15:0]  screen [CELLS];
    int           cur;
    console_out_t pending [$];
    int           errors;

    function void clear_state();
      int i;
      for (i = 0; i < CELLS; i++) screen[i] = 16'h0;
      cur = 0;
      errors = 0;
    endfunction

    function int clamp_pos(logic [6:0] c, logic [4:0] r);
      int cc;
      int rr;
      cc = (c >= COLS) ? COLS - 1 : c;
      rr = (r >= ROWSN) ? ROWSN - 1 : r;
      return rr * COLS + cc;
    endfunction

    function void scroll_up();
      int i;
      for (i = COLS; i + COLS < CELLS; i++) screen[i] = screen[i + COLS];
      for (i = CELLS - COLS; i < CELLS; i++) screen[i] = {screen[i][15:8], CH_SP};
    endfunction

    function void note_beat(logic [1:0] op, logic [7:0] code, logic [7:0] attr,
                            logic [6:0] c, logic [4:0] r);
      console_out_t e;
      int pos;
      int i;
      e = '0;
      case (op)
        OP_PUT: begin
          pos = cur;
          if (code == CH_NL) begin
            pos += COLS;
          end else if (code == CH_CR) begin
            pos -= pos % COLS;
          end else if (code == CH_TAB) begin
            pos += 8 - (pos % 8);
          end else if (code == CH_BS) begin
            if (pos != 0) begin
              pos--;
              screen[pos] = {screen[pos][15:8], CH_SP};
            end
          end else begin
            screen[pos] = {attr, code};
            pos++;
          end
          if (pos >= CELLS) begin
            scroll_up();
            pos -= COLS;
            e.scrolled = 1'b1;
          end
          cur = pos;
        end
        OP_READ: begin
          pos = clamp_pos(c, r);
          e.cell_char = screen[pos][7:0];
          e.cell_attr = screen[pos][15:8];
        end
        OP_CLEAR: begin
          for (i = 0; i < CELLS; i++) screen[i] = {attr, 8'h0};
          cur = clamp_pos(c, r);
        end
        default: cur = clamp_pos(c, r);
      endcase
      e.cursor = cur[10:0];
      pending.push_back(e);
    endfunction

    function void check_beat(console_out_t got);
      console_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.cursor !== e.cursor) begin
        $display("%0t: cursor exp %0d got %0d", $time, e.cursor, got.cursor);
        errors++;
      end
      if (got.cell_char !== e.cell_char) begin
        $display("%0t: cell_char exp %h got %h", $time, e.cell_char, got.cell_char);
        errors++;
      end
      if (got.cell_attr !== e.cell_attr) begin
        $display("%0t: cell_attr exp %h got %h", $time, e.cell_attr, got.cell_attr);
        errors++;
      end
      if (got.scrolled !== e.scrolled) begin
        $display("%0t: scrolled exp %b got %b", $time, e.scrolled, got.scrolled);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] op;
  logic [7:0] code, attribute, cell_char, cell_attr;
  logic [6:0] column;
  logic [4:0] row;
  logic [10:0] cursor;
  logic scrolled;

  console_scoreboard sb;
  int cycles;

  text_console_engine_core #(.COLUMNS(COLS), .ROWS(ROWSN)) u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .code(code), .attribute(attribute), .column(column), .row(row),
    .out_valid(out_valid), .out_ready(out_ready), .cursor(cursor),
    .cell_char(cell_char), .cell_attr(cell_attr), .scrolled(scrolled)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    sb = new();
    sb.clear_state();
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random stalls, check on every accepted beat
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_valid && out_ready)
        sb.check_beat({cursor, cell_char, cell_attr, scrolled});
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 9) < 2) begin
        stall = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // valid stays high from one beat into a back-to-back next one
  task automatic send_beat(logic [1:0] o, logic [7:0] c, logic [7:0] a,
                           logic [6:0] col, logic [4:0] r);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    code <= c;
    attribute <= a;
    column <= col;
    row <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(o, c, a, col, r);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random();
    int p;
    logic [7:0] c;
    p = $urandom_range(0, 99);
    if (p < 75) begin
      case ($urandom_range(0, 9))
        0: c = CH_NL;
        1: c = CH_CR;
        2: c = CH_TAB;
        3: c = CH_BS;
        default: c = 8'($urandom_range(0, 255));
      endcase
      send_beat(OP_PUT, c, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                5'($urandom_range(0, 31)));
    end else if (p < 90) begin
      send_beat(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
    end else if (p < 98) begin
      send_beat(OP_SETC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
    end else begin
      send_beat(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
    end
  endtask

  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_PUT;
    code = 8'h0;
    attribute = 8'h0;
    column = 7'h0;
    row = 5'h0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: edges, every op and control code
    send_beat(OP_PUT, CH_BS, 8'h00, 7'd0, 5'd0);
    send_beat(OP_PUT, 8'hFF, 8'hFF, 7'd0, 5'd0);
    send_beat(OP_PUT, 8'h00, 8'h00, 7'd0, 5'd0);
    send_beat(OP_PUT, CH_TAB, 8'h12, 7'd0, 5'd0);
    send_beat(OP_PUT, CH_CR, 8'h12, 7'd0, 5'd0);
    send_beat(OP_READ, 8'h0, 8'h0, 7'd0, 5'd0);
    send_beat(OP_READ, 8'h0, 8'h0, 7'd127, 5'd31);
    send_beat(OP_SETC, 8'h0, 8'h0, 7'd79, 5'd24);
    send_beat(OP_PUT, 8'h41, 8'h5A, 7'd0, 5'd0);
    send_beat(OP_SETC, 8'h0, 8'h0, 7'd75, 5'd24);
    send_beat(OP_PUT, CH_TAB, 8'h0, 7'd0, 5'd0);
    send_beat(OP_PUT, CH_NL, 8'h0, 7'd0, 5'd0);
    send_beat(OP_READ, 8'h0, 8'h0, 7'd3, 5'd24);
    send_beat(OP_PUT, CH_BS, 8'hA5, 7'd0, 5'd0);
    send_beat(OP_CLEAR, 8'h0, 8'hC3, 7'd100, 5'd30);
    send_beat(OP_READ, 8'h0, 8'h0, 7'd40, 5'd12);
    send_beat(OP_CLEAR, 8'hFF, 8'h00, 7'd0, 5'd0);
    send_beat(OP_SETC, 8'hFF, 8'hFF, 7'd127, 5'd0);
    send_beat(OP_SETC, 8'h0, 8'h0, 7'd0, 5'd31);
    for (i = 0; i < 1350; i++) begin
      if (i == 600) begin
        // let the result side drain fully before going on
        idle_input();
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_random();
    end
    idle_input();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * COLS * ROWSN + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("text_console_engine_core_tb: done, clean");
    else
      $display("text_console_engine_core_tb: done, errors");
    $finish;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("text_console_engine_core_tb: done, errors");
        $finish;
      end
    end
  end
endmodule
